@@ rtl/bba_pkg.sv @@
// Shared constants for the bitmap block allocator.
// Field widths, command codes and map defaults; no dependencies.
package bba_pkg;

   localparam int MAP_BYTES_DEF = 64;
   localparam int MB_W          = 7;
   localparam int CMD_W         = 2;
   localparam int CNT_W         = 10;
   localparam int IDX_W         = 9;
   localparam int BYTE_BITS     = 8;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [MB_W-1:0]      MAP_BYTES_RST = MB_W'(64);
   localparam logic [BYTE_BITS-1:0] ALL_FREE      = 8'hFF;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

   localparam logic REG_MAP_BYTES = 1'b0;

endpackage

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap block allocator: register file, sequencer and map RAM.
// Depends on bba_pkg, bba_csr, bba_engine, bba_ram.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  command, set_value, bit_count, bit_index
//   rsp_     out        rsp_valid/rsp_ready  status, bit_value, run_start
//   csr_     in/out     psel/penable/pready  map_bytes at byte address 0
//
// One request in flight. Range write steps through the bytes touched; read fetches one byte;
// run search steps through the bytes scanned, up to the map size. Trivial requests: straight to done.
// Every step goes through the one write and one read port of the map RAM.
// After reset a clearing pass fills all MAP_BYTES entries of the map with ones, req_ready low.
// rsp_ready held low stalls the sequencer in its done state once the output register is full.
module bitmap_block_allocator #(
   parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bba_pkg::CMD_W-1:0]    req_command,
   input  logic                         req_set_value,
   input  logic [bba_pkg::CNT_W-1:0]    req_bit_count,
   input  logic [bba_pkg::IDX_W-1:0]    req_bit_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic                         rsp_bit_value,
   output logic [bba_pkg::IDX_W-1:0]    rsp_run_start,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bba_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bba_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bba_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import bba_pkg::*;

   localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

   logic [MB_W-1:0]      map_bytes;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [BYTE_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [BYTE_BITS-1:0] ram_rdata;

   bba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .map_bytes   (map_bytes)
   );

   bba_engine #(
      .MAP_BYTES (MAP_BYTES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .map_bytes     (map_bytes),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_set_value (req_set_value),
      .req_bit_count (req_bit_count),
      .req_bit_index (req_bit_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_bit_value (rsp_bit_value),
      .rsp_run_start (rsp_run_start),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   bba_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (MAP_BYTES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

@@ rtl/bba_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/bba_csr.sv @@
// APB-style register file of the allocator: holds map_bytes.
// Depends on bba_pkg.
module bba_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bba_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [bba_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [bba_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output logic [bba_pkg::MB_W-1:0]    map_bytes
);
   import bba_pkg::*;

   logic [MB_W-1:0] map_bytes_ff;
   logic [MB_W-1:0] map_bytes_in;
   logic            wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_MAP_BYTES;

   always_comb begin
      map_bytes_in = map_bytes_ff;
      if (wr_hit) begin
         map_bytes_in = csr_pwdata[MB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_bytes_ff <= MAP_BYTES_RST;
      end else begin
         map_bytes_ff <= map_bytes_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAP_BYTES) ? CSR_DW'(map_bytes_ff) : '0;
   assign map_bytes  = map_bytes_ff;

endmodule

@@ rtl/bba_engine.sv @@
// Command sequencer of the allocator: clear pass, range write, bit read and
// run search over the byte map; range write read-modify-writes one byte per cycle.
// Depends on bba_pkg; drives the ports of one bba_ram.
module bba_engine #(
   parameter  int MAP_BYTES = bba_pkg::MAP_BYTES_DEF,
   localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bba_pkg::MB_W-1:0]      map_bytes,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bba_pkg::CMD_W-1:0]     req_command,
   input  logic                          req_set_value,
   input  logic [bba_pkg::CNT_W-1:0]     req_bit_count,
   input  logic [bba_pkg::IDX_W-1:0]     req_bit_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic                          rsp_bit_value,
   output logic [bba_pkg::IDX_W-1:0]     rsp_run_start,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [bba_pkg::BYTE_BITS-1:0] ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [bba_pkg::BYTE_BITS-1:0] ram_rdata
);
   import bba_pkg::*;

   localparam int BW  = (AW > MB_W) ? AW : MB_W;
   localparam int PW  = (BW + 3 > CNT_W + 1) ? BW + 3 : CNT_W + 1;
   localparam int NBW = MB_W + 3;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_WRITE = 6'b000100,
      ST_READ  = 6'b001000,
      ST_FIND  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [BW-1:0]         clr_ff, clr_in;
   logic [BW-1:0]         byte_ff, byte_in;
   logic [BW-1:0]         last_ff, last_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic                  val_ff, val_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W:0]        end_ff, end_in;
   logic                  res_status_ff, res_status_in;
   logic                  res_bit_ff, res_bit_in;
   logic [IDX_W-1:0]      res_start_ff, res_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_bit_value_ff, rsp_bit_value_in;
   logic [IDX_W-1:0]      rsp_run_start_ff, rsp_run_start_in;

   logic [MB_W-1:0]       eff;
   logic [NBW-1:0]        nbits;
   logic [CNT_W:0]        sum;
   logic [CNT_W:0]        end_clip;
   logic [CNT_W:0]        end_m1;
   logic [BW-1:0]         start_byte;
   logic [BW-1:0]         byte_nxt;
   logic [BYTE_BITS-1:0]  wr_mask;
   logic [BYTE_BITS-1:0]  wr_byte;
   logic [CNT_W-1:0]      run_scan;
   logic                  hit;
   logic [2:0]            hit_pos;
   logic [PW-1:0]         start_pos;

   assign eff        = (32'(map_bytes) > MAP_BYTES) ? MB_W'(MAP_BYTES) : map_bytes;
   assign nbits      = {eff, 3'b000};
   assign sum        = (CNT_W + 1)'(req_bit_index) + (CNT_W + 1)'(req_bit_count);
   assign end_clip   = (sum > (CNT_W + 1)'(nbits)) ? (CNT_W + 1)'(nbits) : sum;
   assign end_m1     = end_clip - (CNT_W + 1)'(1);
   assign start_byte = BW'(req_bit_index[IDX_W-1:3]);
   assign byte_nxt   = byte_ff + BW'(1);

   // byte mask of the range [idx, end) inside the current byte
   always_comb begin
      logic [PW-1:0] pos;
      for (int j = 0; j < BYTE_BITS; j++) begin
         pos        = PW'({byte_ff, 3'(j)});
         wr_mask[j] = (pos >= PW'(idx_ff)) && (pos < PW'(end_ff));
      end
      wr_byte = (ram_rdata & ~wr_mask) | (val_ff ? wr_mask : '0);
   end

   // run counting over the eight bits of one byte
   always_comb begin
      run_scan = run_ff;
      hit      = 1'b0;
      hit_pos  = '0;
      for (int j = 0; j < BYTE_BITS; j++) begin
         if (!hit) begin
            if (ram_rdata[j]) begin
               run_scan = run_scan + CNT_W'(1);
               if (run_scan == cnt_ff) begin
                  hit     = 1'b1;
                  hit_pos = 3'(j);
               end
            end else begin
               run_scan = '0;
            end
         end
      end
      start_pos = PW'({byte_ff, hit_pos}) + PW'(1) - PW'(cnt_ff);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      run_in        = run_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      res_status_in = res_status_ff;
      res_bit_in    = res_bit_ff;
      res_start_in  = res_start_ff;
      ram_we        = 1'b0;
      ram_waddr     = byte_ff[AW-1:0];
      ram_wdata     = wr_byte;
      ram_raddr     = byte_nxt[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff[AW-1:0];
            ram_wdata = ALL_FREE;
            clr_in    = clr_ff + BW'(1);
            if (clr_ff == BW'(MAP_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               val_in        = req_set_value;
               cnt_in        = req_bit_count;
               idx_in        = req_bit_index;
               end_in        = end_clip;
               res_status_in = 1'b0;
               res_bit_in    = 1'b0;
               res_start_in  = '0;
               state_in      = ST_DONE;
               case (req_command)
                  CMD_WRITE: begin
                     if (req_bit_count != '0 && NBW'(req_bit_index) < nbits) begin
                        byte_in   = start_byte;
                        last_in   = BW'(end_m1[CNT_W:3]);
                        ram_raddr = start_byte[AW-1:0];
                        state_in  = ST_WRITE;
                     end
                  end
                  CMD_READ: begin
                     if (NBW'(req_bit_index) < nbits) begin
                        ram_raddr = start_byte[AW-1:0];
                        state_in  = ST_READ;
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     if (req_bit_count != '0 && eff != '0) begin
                        byte_in   = '0;
                        run_in    = '0;
                        last_in   = BW'(eff) - BW'(1);
                        ram_raddr = '0;
                        state_in  = ST_FIND;
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            // read of byte n+1 overlaps the write of byte n: never the same entry
            ram_we = 1'b1;
            if (byte_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               byte_in = byte_nxt;
            end
         end
         ST_READ: begin
            res_bit_in = ram_rdata[idx_ff[2:0]];
            state_in   = ST_DONE;
         end
         ST_FIND: begin
            if (hit) begin
               res_start_in = start_pos[IDX_W-1:0];
               state_in     = ST_DONE;
            end else if (byte_ff == last_ff) begin
               res_status_in = 1'b1;
               state_in      = ST_DONE;
            end else begin
               byte_in = byte_nxt;
               run_in  = run_scan;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_bit_value_in = rsp_bit_value_ff;
      rsp_run_start_in = rsp_run_start_ff;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = res_status_ff;
         rsp_bit_value_in = res_bit_ff;
         rsp_run_start_in = res_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff          <= byte_in;
      last_ff          <= last_in;
      run_ff           <= run_in;
      val_ff           <= val_in;
      cnt_ff           <= cnt_in;
      idx_ff           <= idx_in;
      end_ff           <= end_in;
      res_status_ff    <= res_status_in;
      res_bit_ff       <= res_bit_in;
      res_start_ff     <= res_start_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_bit_value_ff <= rsp_bit_value_in;
      rsp_run_start_ff <= rsp_run_start_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bit_value = rsp_bit_value_ff;
   assign rsp_run_start = rsp_run_start_ff;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> byte_ff <= last_ff)
      else $error("range write past its last byte");

   a_run_below_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND |-> run_ff < cnt_ff)
      else $error("run counter reached size without a hit");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_fail_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_bit_value_ff == 1'b0 && rsp_run_start_ff == '0)
      else $error("failed response carries data");

endmodule

@@ tb/sv/bitmap_block_allocator_tb.sv @@
// Self-checking testbench for bitmap_block_allocator: directed table, then random phases
// over several map sizes, with a scoreboard fed by a behavioral bitmap predictor.
// Depends on bba_pkg and the RTL top level only.
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
   import bba_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam int IDLE_PCT      = 19;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      logic             status;
      logic             bit_value;
      logic [IDX_W-1:0] run_start;
   } alloc_result_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             val;
      logic [CNT_W-1:0] cnt;
      logic [IDX_W-1:0] idx;
      logic             typed;
      alloc_result_type want;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic                req_set_value;
   logic [CNT_W-1:0]    req_bit_count;
   logic [IDX_W-1:0]    req_bit_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_status;
   logic                rsp_bit_value;
   logic [IDX_W-1:0]    rsp_run_start;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   logic [BYTE_BITS*MAP_BYTES_DEF-1:0] free_map;
   logic [MB_W-1:0]                    map_bytes_cfg;
   alloc_result_type                   pending_results[$];
   dir_row_type                        dir_rows[$];
   int                                 fail_count;
   bit                                 no_idle;
   bit                                 hold_request;

   bitmap_block_allocator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_set_value (req_set_value),
      .req_bit_count (req_bit_count),
      .req_bit_index (req_bit_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_bit_value (rsp_bit_value),
      .rsp_run_start (rsp_run_start),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned map_bits();
      int unsigned nbytes;
      nbytes = int'(map_bytes_cfg);
      if (nbytes > MAP_BYTES_DEF) nbytes = MAP_BYTES_DEF;
      return nbytes * BYTE_BITS;
   endfunction

   function automatic alloc_result_type predict_alloc(input logic [CMD_W-1:0] cmd,
                                                      input logic val,
                                                      input logic [CNT_W-1:0] cnt,
                                                      input logic [IDX_W-1:0] idx);
      alloc_result_type r;
      int unsigned      nbits;
      int unsigned      stop;
      int unsigned      run;
      bit               found;
      r = '0;
      run = 0;
      found = 1'b0;
      nbits = map_bits();
      case (cmd)
         CMD_WRITE: begin
            stop = int'(idx) + int'(cnt);
            if (stop > nbits) stop = nbits;
            for (int unsigned k = idx; k < stop; k++) free_map[k] = val;
         end
         CMD_READ: begin
            if (idx < nbits) r.bit_value = free_map[idx];
            else r.status = 1'b1;
         end
         CMD_FIND: begin
            if (cnt != 0) begin
               for (int unsigned k = 0; k < nbits && !found; k++) begin
                  if (free_map[k]) begin
                     run++;
                     if (run == cnt) begin
                        r.run_start = IDX_W'(k + 1 - cnt);
                        found = 1'b1;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
            if (!found) begin
               r.status = 1'b1;
               r.run_start = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic dir_row_type make_row(input logic [CMD_W-1:0] cmd, input logic val,
                                            input int cnt, input int idx, input logic typed,
                                            input logic st, input logic bv, input int rs);
      dir_row_type row;
      row.cmd = cmd;
      row.val = val;
      row.cnt = CNT_W'(cnt);
      row.idx = IDX_W'(idx);
      row.typed = typed;
      row.want.status = st;
      row.want.bit_value = bv;
      row.want.run_start = IDX_W'(rs);
      return row;
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic val,
                               input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx,
                               input logic typed, input alloc_result_type want);
      alloc_result_type got;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_set_value = val;
      req_bit_count = cnt;
      req_bit_index = idx;
      do @(posedge clock); while (!req_ready);
      got = predict_alloc(cmd, val, cnt, idx);
      pending_results.push_back(typed ? want : got);
   endtask

   task automatic wait_idle(input int settle);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_map_bytes(input logic [MB_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_AW'({REG_MAP_BYTES, 2'b00});
      csr_pwdata = ($urandom & ~32'h7F) | CSR_DW'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      map_bytes_cfg = value;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic run_random(input int n);
      logic [CMD_W-1:0] cmd;
      logic             val;
      logic [CNT_W-1:0] cnt;
      logic [IDX_W-1:0] idx;
      int unsigned      nb;
      int unsigned      roll;
      int unsigned      size_roll;
      for (int i = 0; i < n; i++) begin
         nb = map_bits();
         roll = $urandom_range(99);
         size_roll = $urandom_range(99);
         val = ($urandom_range(99) < 55);
         idx = (nb != 0 && $urandom_range(99) < 85) ? IDX_W'($urandom_range(nb - 1))
                                                    : IDX_W'($urandom);
         cnt = CNT_W'($urandom);
         if (roll < 40) begin
            cmd = CMD_WRITE;
            if (size_roll < 55) cnt = CNT_W'($urandom_range(16));
            else if (size_roll < 90) cnt = CNT_W'($urandom_range(160));
         end else if (roll < 65) begin
            cmd = CMD_READ;
         end else if (roll < 96) begin
            cmd = CMD_FIND;
            if (size_roll < 80) cnt = CNT_W'($urandom_range(20, 1));
            else if (size_roll < 92) cnt = CNT_W'($urandom_range(520));
         end else begin
            cmd = CMD_NONE;
         end
         send_request(cmd, val, cnt, idx, 1'b0, '0);
      end
   endtask

   // scoreboard
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status %0b bit_value %0b run_start %0d",
                     $time, rsp_status, rsp_bit_value, rsp_run_start);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_bit_value !== want.bit_value) begin
               $display("%0t: bit_value expected %0b actual %0b", $time, want.bit_value,
                        rsp_bit_value);
               fail_count++;
            end
            if (rsp_run_start !== want.run_start) begin
               $display("%0t: run_start expected %0d actual %0d", $time, want.run_start,
                        rsp_run_start);
               fail_count++;
            end
         end
      end
   end

   // response sink with random backpressure and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_set_value = 1'b0;
      req_bit_count = '0;
      req_bit_index = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fail_count = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      free_map = '1;
      map_bytes_cfg = MAP_BYTES_RST;

      dir_rows.push_back(make_row(CMD_READ,  1'b0,    0,   0, 1'b1, 1'b0, 1'b1,   0));
      dir_rows.push_back(make_row(CMD_READ,  1'b0,    0, 511, 1'b1, 1'b0, 1'b1,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,  512, 511, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b1,    0,   0, 1'b1, 1'b1, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,  513,   0, 1'b1, 1'b1, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b1, 1023, 511, 1'b1, 1'b1, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_NONE,  1'b1, 1023, 511, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b0,    0,   5, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_READ,  1'b0,    0,   5, 1'b1, 1'b0, 1'b1,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b0, 1023,   0, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,    1,   0, 1'b1, 1'b1, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_READ,  1'b1,    0, 511, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b1,  512, 500, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,   12,   0, 1'b1, 1'b0, 1'b0, 500));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,   13,   0, 1'b1, 1'b1, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_READ,  1'b0,    0, 499, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b1,    1,   0, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,    1,   0, 1'b1, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b1,  300,   3, 1'b0, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,  200,   0, 1'b0, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_WRITE, 1'b0,    7, 255, 1'b0, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_FIND,  1'b0,  300,   0, 1'b0, 1'b0, 1'b0,   0));
      dir_rows.push_back(make_row(CMD_READ,  1'b0,    0, 256, 1'b0, 1'b0, 1'b0,   0));

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].cnt, dir_rows[i].idx,
                      dir_rows[i].typed, dir_rows[i].want);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(1));
      run_random(110);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(0));
      run_random(60);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(127));
      hold_request = 1'b1;
      run_random(130);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(8));
      no_idle = 1'b1;
      run_random(130);
      no_idle = 1'b0;
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'($urandom_range(63, 2)));
      run_random(130);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(100));
      run_random(120);
      wait_idle(SETTLE_CYCLES);

      write_map_bytes(MB_W'(64));
      run_random(250);
      wait_idle(TAIL_CYCLES);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
